// ===== rtl/cfr_pkg.sv =====
package cfr_pkg;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_START   = 3'd1,
        EV_HEADER  = 3'd2,
        EV_PAYLOAD = 3'd3,
        EV_GOOD    = 3'd4,
        EV_BAD     = 3'd5,
        EV_DROPPED = 3'd6
    } event_t;

    typedef enum logic {
        REG_START_MARKER = 1'b0,
        REG_MAX_PAYLOAD  = 1'b1
    } cfg_index_t;

    localparam logic [7:0] START_MARKER_RESET = 8'd170;
    localparam logic [7:0] MAX_PAYLOAD_RESET  = 8'd252;
    localparam logic [8:0] HEADER_BYTES       = 9'd3;
    localparam logic [8:0] CMD_BYTE_COUNT     = 9'd2;

endpackage

// ===== rtl/command_frame_receiver_top.sv =====
// Command frame receiver. Takes one received byte per transaction on the s_ side and
// returns exactly one result transaction per byte on the m_ side, in order. Frames are
// start_marker, command, length, payload[length], check; the check byte is compared
// with the XOR of all earlier frame bytes. Payload bytes stream out as they arrive.
// A frame whose length exceeds max_payload is dropped at its length byte. Each byte
// passes through an input register and a result register, so a byte is accepted every
// cycle while the m_ side is ready; the frame-state decode between the two registers is
// combinational. Write cfg registers only while idle.
module command_frame_receiver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] command_code, [15:8] frame_length,
                                   // [23:16] data_byte, [31:24] data_index
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast    // frame_end
);

    logic [7:0]      start_marker_reg;
    logic [7:0]      max_payload_reg;

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;

    cfr_pkg::phase_t phase_reg, phase_next;
    logic [8:0]      byte_count_reg, byte_count_next;
    logic [7:0]      length_reg, length_next;
    logic [7:0]      command_reg, command_next;
    logic [7:0]      check_reg, check_next;

    cfr_pkg::event_t ev_next;
    logic [7:0]      cmd_next, len_next, dbyte_next, didx_next;
    logic            fend_next;
    logic [8:0]      payload_end;

    logic            out_valid_reg;
    cfr_pkg::event_t ev_reg;
    logic [7:0]      cmd_reg, len_reg, dbyte_reg, didx_reg;
    logic            fend_reg;

    logic            advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= cfr_pkg::START_MARKER_RESET;
            max_payload_reg  <= cfr_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            case (cfr_pkg::cfg_index_t'(cfg_index))
                cfr_pkg::REG_START_MARKER: start_marker_reg <= cfg_wdata;
                cfr_pkg::REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    assign payload_end = cfr_pkg::HEADER_BYTES + {1'b0, length_reg};

    always_comb begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        length_next     = length_reg;
        command_next    = command_reg;
        check_next      = check_reg;
        ev_next         = cfr_pkg::EV_IGNORED;
        cmd_next        = 8'd0;
        len_next        = 8'd0;
        dbyte_next      = 8'd0;
        didx_next       = 8'd0;
        fend_next       = 1'b0;
        case (phase_reg)
            cfr_pkg::PH_WAIT: begin
                if (in_byte_reg == start_marker_reg) begin
                    check_next      = in_byte_reg;
                    byte_count_next = 9'd1;
                    length_next     = 8'd0;
                    command_next    = 8'd0;
                    phase_next      = cfr_pkg::PH_HEADER;
                    ev_next         = cfr_pkg::EV_START;
                end
            end
            cfr_pkg::PH_HEADER: begin
                if (byte_count_reg <= 9'd1) begin
                    command_next    = in_byte_reg;
                    check_next      = check_reg ^ in_byte_reg;
                    byte_count_next = cfr_pkg::CMD_BYTE_COUNT;
                    ev_next         = cfr_pkg::EV_HEADER;
                    cmd_next        = in_byte_reg;
                end else begin
                    cmd_next = command_reg;
                    len_next = in_byte_reg;
                    if (in_byte_reg > max_payload_reg) begin
                        ev_next         = cfr_pkg::EV_DROPPED;
                        fend_next       = 1'b1;
                        phase_next      = cfr_pkg::PH_WAIT;
                        byte_count_next = 9'd0;
                        length_next     = 8'd0;
                        command_next    = 8'd0;
                        check_next      = 8'd0;
                    end else begin
                        length_next     = in_byte_reg;
                        check_next      = check_reg ^ in_byte_reg;
                        byte_count_next = cfr_pkg::HEADER_BYTES;
                        phase_next      = cfr_pkg::PH_PAYLOAD;
                        ev_next         = cfr_pkg::EV_HEADER;
                    end
                end
            end
            cfr_pkg::PH_PAYLOAD: begin
                cmd_next = command_reg;
                len_next = length_reg;
                if (byte_count_reg < payload_end) begin
                    ev_next         = cfr_pkg::EV_PAYLOAD;
                    dbyte_next      = in_byte_reg;
                    didx_next       = 8'(byte_count_reg - cfr_pkg::HEADER_BYTES);
                    check_next      = check_reg ^ in_byte_reg;
                    byte_count_next = byte_count_reg + 9'd1;
                end else begin
                    ev_next         = (check_reg == in_byte_reg) ? cfr_pkg::EV_GOOD
                                                                 : cfr_pkg::EV_BAD;
                    fend_next       = 1'b1;
                    phase_next      = cfr_pkg::PH_WAIT;
                    byte_count_next = 9'd0;
                    length_next     = 8'd0;
                    command_next    = 8'd0;
                    check_next      = 8'd0;
                end
            end
            default: begin
                phase_next      = cfr_pkg::PH_WAIT;
                byte_count_next = 9'd0;
                length_next     = 8'd0;
                command_next    = 8'd0;
                check_next      = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= cfr_pkg::PH_WAIT;
            byte_count_reg <= 9'd0;
            length_reg     <= 8'd0;
            command_reg    <= 8'd0;
            check_reg      <= 8'd0;
        end else if (advance) begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            length_reg     <= length_next;
            command_reg    <= command_next;
            check_reg      <= check_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ev_reg    <= ev_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            dbyte_reg <= dbyte_next;
            didx_reg  <= didx_next;
            fend_reg  <= fend_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {didx_reg, dbyte_reg, len_reg, cmd_reg};
    assign m_tuser  = ev_reg;
    assign m_tlast  = fend_reg;

endmodule
